@@ hw/rtl/min_priority_queue_linear_macros.svh @@
// assertion shorthands shared by the queue modules
`ifndef MIN_PRIORITY_QUEUE_LINEAR_MACROS_SVH
`define MIN_PRIORITY_QUEUE_LINEAR_MACROS_SVH

// checked on every clock edge outside reset
`define MPQL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define MPQL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hw/rtl/mpql_pkg.sv @@
package mpql_pkg;

    // field widths
    localparam int ID_W      = 16;
    localparam int PRIO_W    = 15;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 7;
    localparam int DEPTH_DEF = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PROCESS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPGRADE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   patient_id;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } rsp_t;

    // one stored queue entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // what the array walk does with each entry it reads
    typedef enum logic [1:0] {
        WALK_MIN   = 2'd0,
        WALK_SHIFT = 2'd1,
        WALK_UPG   = 2'd2
    } walk_mode_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       ins_write;
        logic       clear_all;
        logic       walk_start;
        logic       walk_from_best;
        logic       walk_run;
        walk_mode_t walk_mode;
        logic       cnt_dec;
        logic       load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_done;
        logic out_free;
        logic req_is_process;
    } dp_status_t;

endpackage

@@ hw/rtl/min_priority_queue_linear.sv @@
// channel   ports                       payload                  taken when
// request   s_valid s_ready s_data      command id priority      s_valid & s_ready
// result    m_valid m_ready m_data      id priority status occ   m_valid & m_ready
//
// one request at a time; insert, clear, unused codes, empty peek or process go to finish
// peek, process and upgrade walk all n entries; process then walks again from its front
// at p, shifting later entries down, through the RAM's single read port, one read a cycle
// a new request is taken while the previous result waits in the output register,
// and a result still untaken there holds the next one back in its last cycle
// aresetn is synchronous, active low, and empties the queue; no clearing pass
`default_nettype none

module min_priority_queue_linear #(
    parameter int DEPTH = mpql_pkg::DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire mpql_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output mpql_pkg::rsp_t      m_data
);

    import mpql_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // sequencing
    mpql_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_data.command),
        .status_i  (dp_status),
        .cmd_o     (dp_cmd)
    );

    // entry storage, walk and result register
    mpql_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cmd_i    (dp_cmd),
        .status_o (dp_status),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mpql_ram.sv @@
`default_nettype none

module mpql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mpql_dp.sv @@
`default_nettype none
`include "min_priority_queue_linear_macros.svh"

module mpql_dp #(
    parameter int DEPTH = mpql_pkg::DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mpql_pkg::req_t      s_data,
    input  wire mpql_pkg::dp_cmd_t   cmd_i,
    output mpql_pkg::dp_status_t     status_o,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mpql_pkg::rsp_t           m_data
);

    import mpql_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t              req_reg;
    logic [STAT_W-1:0] stat_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              vld_reg;
    logic [AW-1:0]     data_idx_reg;
    logic [AW-1:0]     best_pos_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic              hit_reg;
    rsp_t              m_data_reg;
    logic              m_valid_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;
    logic              full;
    logic              empty;
    logic              step;
    logic              id_match;
    logic              take_best;
    logic              front_cmd;
    rsp_t              rsp_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign step      = cmd_i.walk_run && vld_reg;
    assign id_match  = (ram_rdata.id == req_reg.patient_id);
    assign take_best = (data_idx_reg == '0) || (ram_rdata.prio < best_prio_reg);

    // entry storage
    mpql_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // write port select: append, shift down or priority rewrite
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = data_idx_reg;
        ram_wdata = ram_rdata;
        if (cmd_i.ins_write) begin
            ram_we         = 1'b1;
            ram_waddr      = cnt_reg[AW-1:0];
            ram_wdata.id   = s_data.patient_id;
            ram_wdata.prio = s_data.priority_req;
        end else if (step && cmd_i.walk_mode == WALK_SHIFT) begin
            ram_we    = 1'b1;
            ram_waddr = data_idx_reg - AW'(1);
        end else if (step && cmd_i.walk_mode == WALK_UPG && id_match) begin
            ram_we         = 1'b1;
            ram_wdata.prio = req_reg.priority_req;
        end
    end

    // request capture and early status
    always_ff @(posedge aclk) begin
        if (cmd_i.accept) begin
            req_reg  <= s_data;
            stat_reg <= STAT_OK;
            if (s_data.command == CMD_INSERT && full) begin
                stat_reg <= STAT_FULL;
            end else if ((s_data.command == CMD_PROCESS || s_data.command == CMD_PEEK)
                         && empty) begin
                stat_reg <= STAT_EMPTY;
            end
        end
    end

    // occupancy count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd_i.clear_all) begin
            cnt_reg <= '0;
        end else if (cmd_i.ins_write) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd_i.cnt_dec) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // array walk: one read issued per cycle, its data returned in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else if (cmd_i.walk_start) begin
            idx_reg <= cmd_i.walk_from_best ? CNT_W'(best_pos_reg) + CNT_W'(1) : '0;
            vld_reg <= 1'b0;
        end else if (cmd_i.walk_run) begin
            if (idx_reg < cnt_reg) begin
                idx_reg <= idx_reg + CNT_W'(1);
                vld_reg <= 1'b1;
            end else begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_idx_reg <= idx_reg[AW-1:0];
    end

    // running minimum, earliest entry kept on ties
    always_ff @(posedge aclk) begin
        if (step && cmd_i.walk_mode == WALK_MIN && take_best) begin
            best_pos_reg  <= data_idx_reg;
            best_prio_reg <= ram_rdata.prio;
            best_id_reg   <= ram_rdata.id;
        end
    end

    // id match flag for upgrade
    always_ff @(posedge aclk) begin
        if (cmd_i.accept) begin
            hit_reg <= 1'b0;
        end else if (step && cmd_i.walk_mode == WALK_UPG && id_match) begin
            hit_reg <= 1'b1;
        end
    end

    // result assembly
    assign front_cmd = (req_reg.command == CMD_PROCESS || req_reg.command == CMD_PEEK)
                       && stat_reg == STAT_OK;

    always_comb begin
        rsp_next.out_id       = front_cmd ? best_id_reg : '0;
        rsp_next.out_priority = front_cmd ? best_prio_reg : '0;
        rsp_next.status       = (req_reg.command == CMD_UPGRADE && !hit_reg)
                                ? STAT_NOTFOUND : stat_reg;
        rsp_next.occupancy    = OCC_W'(cnt_reg);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_out) begin
            m_data_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // status to controller
    assign status_o.empty          = empty;
    assign status_o.full           = full;
    assign status_o.walk_done      = cmd_i.walk_run && !vld_reg && (idx_reg == cnt_reg);
    assign status_o.out_free       = !m_valid_reg || m_ready;
    assign status_o.req_is_process = (req_reg.command == CMD_PROCESS);

    `MPQL_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(DEPTH), "entry count above depth")
    `MPQL_ASSERT(a_walk_wr_range, (ram_we && !cmd_i.ins_write) |-> (CNT_W'(ram_waddr) < cnt_reg), "walk write outside held entries")
    `MPQL_ASSERT(a_load_free, cmd_i.load_out |-> (!m_valid_reg || m_ready), "result loaded over an untaken result")
    `MPQL_ASSERT(a_dec_nonempty, cmd_i.cnt_dec |-> !empty, "removal from empty queue")

endmodule

`default_nettype wire

@@ hw/rtl/mpql_ctrl.sv @@
`default_nettype none
`include "min_priority_queue_linear_macros.svh"

module mpql_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [mpql_pkg::CMD_W-1:0] s_command,
    input  wire mpql_pkg::dp_status_t       status_i,
    output mpql_pkg::dp_cmd_t               cmd_o
);

    import mpql_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MIN    = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_UPG    = 5'b01000,
        ST_FINISH = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        cmd_o.walk_mode = WALK_MIN;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_o.accept = 1'b1;
                    state_next   = ST_FINISH;
                    unique case (s_command) inside
                        CMD_INSERT: begin
                            cmd_o.ins_write = !status_i.full;
                        end
                        CMD_PROCESS, CMD_PEEK: begin
                            if (!status_i.empty) begin
                                cmd_o.walk_start = 1'b1;
                                state_next       = ST_MIN;
                            end
                        end
                        CMD_UPGRADE: begin
                            cmd_o.walk_start = 1'b1;
                            state_next       = ST_UPG;
                        end
                        CMD_CLEAR: begin
                            cmd_o.clear_all = 1'b1;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MIN: begin
                cmd_o.walk_run  = 1'b1;
                cmd_o.walk_mode = WALK_MIN;
                if (status_i.walk_done) begin
                    if (status_i.req_is_process) begin
                        cmd_o.walk_start     = 1'b1;
                        cmd_o.walk_from_best = 1'b1;
                        state_next           = ST_SHIFT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SHIFT: begin
                cmd_o.walk_run  = 1'b1;
                cmd_o.walk_mode = WALK_SHIFT;
                if (status_i.walk_done) begin
                    cmd_o.cnt_dec = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_UPG: begin
                cmd_o.walk_run  = 1'b1;
                cmd_o.walk_mode = WALK_UPG;
                if (status_i.walk_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status_i.out_free) begin
                    cmd_o.load_out = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `MPQL_ASSERT(a_accept_leaves_idle, (s_valid && s_ready) |=> (state_reg != ST_IDLE), "idle after a request")
    `MPQL_ASSERT(a_state_onehot, $onehot(state_reg), "controller state not one-hot")

endmodule

`default_nettype wire

@@ test/pq_result_checker.sv @@
module pq_result_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wire mpql_pkg::req_t s_data,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire mpql_pkg::rsp_t m_data,
    output int                  fail_count,
    output int                  outstanding
);

    import mpql_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // mirror of the queue contents, oldest insert first
    entry_t held[DEPTH_DEF];
    int     held_count;

    // results owed by the block, oldest request first
    rsp_t   owed_rsp[$];

    initial begin
        held_count  = 0;
        fail_count  = 0;
        outstanding = 0;
    end

    // apply one request to the mirror and return the result it must produce
    function automatic rsp_t serve_request(req_t r);
        rsp_t rsp;
        int   front;
        bit   hit;
        rsp = '0;
        rsp.status = STAT_OK;
        case (r.command) inside
            CMD_INSERT: begin
                if (held_count >= DEPTH_DEF) begin
                    rsp.status = STAT_FULL;
                end else begin
                    held[held_count] = '{id: r.patient_id, prio: r.priority_req};
                    held_count++;
                end
            end
            CMD_PROCESS, CMD_PEEK: begin
                if (held_count == 0) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    // strict less-than keeps the earliest entry on ties
                    front = 0;
                    for (int i = 1; i < held_count; i++) begin
                        if (held[i].prio < held[front].prio) front = i;
                    end
                    rsp.out_id       = held[front].id;
                    rsp.out_priority = held[front].prio;
                    if (r.command == CMD_PROCESS) begin
                        for (int i = front; i + 1 < held_count; i++) held[i] = held[i + 1];
                        held_count--;
                    end
                end
            end
            CMD_UPGRADE: begin
                hit = 1'b0;
                for (int i = 0; i < held_count; i++) begin
                    if (held[i].id == r.patient_id) begin
                        held[i].prio = r.priority_req;
                        hit = 1'b1;
                    end
                end
                if (!hit) rsp.status = STAT_NOTFOUND;
            end
            CMD_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        rsp.occupancy = OCC_W'(held_count);
        return rsp;
    endfunction

    // results are matched before new requests so a same-edge pair stays in order
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            held_count = 0;
            owed_rsp.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: id %h prio %h status %0d occ %0d",
                                 m_data.out_id, m_data.out_priority, m_data.status,
                                 m_data.occupancy);
                end else begin
                    want = owed_rsp.pop_front();
                    if (m_data.out_id !== want.out_id ||
                        m_data.out_priority !== want.out_priority ||
                        m_data.status !== want.status ||
                        m_data.occupancy !== want.occupancy) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"result mismatch: id %h/%h prio %h/%h status %0d/%0d",
                                      " occ %0d/%0d (got/expected)"},
                                     m_data.out_id, want.out_id,
                                     m_data.out_priority, want.out_priority,
                                     m_data.status, want.status,
                                     m_data.occupancy, want.occupancy);
                    end
                end
            end
            if (s_valid && s_ready) owed_rsp = {owed_rsp, serve_request(s_data)};
        end
        outstanding <= owed_rsp.size();
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    import mpql_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REQUEST_GOAL  = 500;
    localparam int FILL_AT       = 250;
    localparam int FILL_EXTRA    = 2;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_CLEAR + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    int fail_count;
    int outstanding;
    int requests_sent = 0;
    int burst_left    = 0;
    int cycle_count   = 0;

    min_priority_queue_linear #(
        .DEPTH(DEPTH_DEF)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    pq_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // mostly a small pool so upgrades hit and ids repeat
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 70) return ID_W'($urandom_range(0, 7));
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    // small values for ties, some extremes, the rest full range
    function automatic logic [PRIO_W-1:0] pick_priority();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return PRIO_W'($urandom_range(0, 7));
        if (roll < 45) return $urandom_range(0, 1) ? '1 : '0;
        return PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
    endfunction

    // offer one request, hold it until taken, then maybe end the burst
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                         input logic [PRIO_W-1:0] prio);
        int gap;
        s_data  <= '{command: cmd, patient_id: id, priority_req: prio};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // result side stall pattern, with one long hold-off mid run
    initial begin
        int  mode;
        int  span;
        bit  held_off;
        held_off = 1'b0;
        forever begin
            if (!held_off && requests_sent >= HOLD_AT) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // request stream and verdict
    initial begin
        int  roll;
        int  insert_pct;
        int  segment_len;
        bit  filled;
        logic [CMD_W-1:0] cmd;
        filled = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue cases and unused codes
        issue(CMD_PROCESS, 16'h0000, 15'h0000);
        issue(CMD_PEEK, 16'hFFFF, 15'h7FFF);
        issue(CMD_UPGRADE, 16'h0001, 15'h0003);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            issue(CMD_W'(c), 16'hA5A5, 15'h5A5A);

        // largest priority is still found
        issue(CMD_INSERT, 16'hFFFF, 15'h7FFF);
        issue(CMD_PEEK, 16'h0000, 15'h0000);

        // ties, duplicate ids, upgrade of both duplicates
        issue(CMD_INSERT, 16'h0000, 15'h0000);
        issue(CMD_INSERT, 16'h1234, 15'h0000);
        issue(CMD_INSERT, 16'hFFFF, 15'h0005);
        issue(CMD_PEEK, 16'h0000, 15'h0000);
        issue(CMD_UPGRADE, 16'hFFFF, 15'h0000);
        issue(CMD_UPGRADE, 16'hBEEF, 15'h0001);
        repeat (5) issue(CMD_PROCESS, 16'h0000, 15'h0000);

        // clear with entries and on an empty queue
        issue(CMD_INSERT, 16'h5555, 15'h2AAA);
        issue(CMD_INSERT, 16'hAAAA, 15'h5555);
        issue(CMD_CLEAR, 16'h0000, 15'h0000);
        issue(CMD_PEEK, 16'h0000, 15'h0000);
        issue(CMD_CLEAR, 16'hFFFF, 15'h7FFF);

        // random segments with a drifting mix, plus one fill to overflow and drain
        while (requests_sent < REQUEST_GOAL) begin
            if (!filled && requests_sent >= FILL_AT) begin
                filled = 1'b1;
                issue(CMD_CLEAR, pick_id(), pick_priority());
                repeat (DEPTH_DEF + FILL_EXTRA) issue(CMD_INSERT, pick_id(), pick_priority());
                issue(CMD_UPGRADE, pick_id(), pick_priority());
                repeat (DEPTH_DEF + FILL_EXTRA) issue(CMD_PROCESS, pick_id(), pick_priority());
            end
            case ($urandom_range(0, 2))
                0: insert_pct = 65;
                1: insert_pct = 20;
                default: insert_pct = 40;
            endcase
            segment_len = $urandom_range(8, 40);
            repeat (segment_len) begin
                if ($urandom_range(0, 99) < insert_pct) begin
                    cmd = CMD_INSERT;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55)      cmd = CMD_PROCESS;
                    else if (roll < 70) cmd = CMD_PEEK;
                    else if (roll < 92) cmd = CMD_UPGRADE;
                    else if (roll < 96) cmd = CMD_CLEAR;
                    else                cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                end
                issue(cmd, pick_id(), pick_priority());
            end
        end
        s_valid <= 1'b0;

        // let every result come back, then watch for strays
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
